@@ sv/sliding_mode_rotor_angle_observer_assert.svh @@
// Assertion macros shared by the observer modules.
`ifndef SLIDING_MODE_ROTOR_ANGLE_OBSERVER_ASSERT_SVH
`define SLIDING_MODE_ROTOR_ANGLE_OBSERVER_ASSERT_SVH

// Implication checked every clock, off during reset.
`define SMO_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define SMO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/smo_pkg.sv @@
package smo_pkg;

  localparam int unsigned GainW = 15;
  localparam int unsigned DataW = 16;
  localparam int unsigned CordicSteps = 10;
  localparam logic signed [31:0] ErrLimit = 32'sd16383;

  localparam logic [1:0] RegInputGain  = 2'd0;
  localparam logic [1:0] RegDecayGain  = 2'd1;
  localparam logic [1:0] RegSwitchGain = 2'd2;
  localparam logic [1:0] RegFilterCoef = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EST_A,
    ST_EST_B,
    ST_ERR,
    ST_CORR,
    ST_EMF_D,
    ST_EMF,
    ST_NORM,
    ST_FOLD,
    ST_ROT,
    ST_OUT
  } smo_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EST_A,
    OP_EST_B,
    OP_ERR,
    OP_CORR,
    OP_EMF_D,
    OP_EMF,
    OP_NORM,
    OP_FOLD,
    OP_ROT
  } smo_op_t;

  typedef struct packed {
    smo_op_t    op;
    logic       axis;   // 0 alpha, 1 beta
    logic [3:0] step;   // CORDIC step index
    logic       out_load;
  } smo_cmd_t;

  function automatic logic [15:0] cordic_atan(input logic [3:0] i);
    logic [15:0] r;
    begin
      unique case (i)
        4'd0: r = 16'd8192;
        4'd1: r = 16'd4836;
        4'd2: r = 16'd2555;
        4'd3: r = 16'd1297;
        4'd4: r = 16'd651;
        4'd5: r = 16'd326;
        4'd6: r = 16'd163;
        4'd7: r = 16'd81;
        4'd8: r = 16'd41;
        4'd9: r = 16'd20;
        default: r = 16'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/sliding_mode_rotor_angle_observer.sv @@
// Sliding-mode rotor angle observer. One transfer in (alpha/beta voltage and
// current, Q15) gives one transfer out (angle, filtered back-EMF pair).
// The steps run in order: a shared 32x32 multiplier handles the four Q15
// products per axis serially, alpha first and then beta, followed by one
// normalize, one quadrant fold, 10 CORDIC steps and a load of the output
// register. A new item is taken only once the block is back in idle; a
// stalled result holds the block in its output state, so the next item
// waits until the result register is free. Config writes only while idle;
// the register index is two bits.
module sliding_mode_rotor_angle_observer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // voltage_alpha[15:0], voltage_beta[31:16], current_alpha[47:32], current_beta[63:48]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rotor_angle[15:0], emf_alpha[31:16], emf_beta[47:32]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import smo_pkg::*;
  `include "sliding_mode_rotor_angle_observer_assert.svh"

  smo_cmd_t    cmd;
  logic        in_ready_c;
  logic [15:0] r_ang, r_ea, r_eb;
  logic        out_busy;

  assign out_busy      = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = in_ready_c;

  smo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_axis_tvalid && in_ready_c),
    .out_busy (out_busy),
    .in_ready (in_ready_c),
    .cmd      (cmd)
  );

  smo_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .res_angle (r_ang),
    .res_emf_a (r_ea),
    .res_emf_b (r_eb)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_axis_tdata <= {r_eb, r_ea, r_ang};
  end

  `SMO_ASSERT_IMPL(a_load_free, clk, rst, cmd.out_load, !out_busy)
  `SMO_ASSERT_NEXT(a_load_valid, clk, rst, cmd.out_load, m_axis_tvalid)
  `SMO_ASSERT_IMPL(a_no_take_busy, clk, rst, cmd.op != OP_NONE && cmd.op != OP_LOAD, !s_axis_tready)
endmodule

@@ sv/smo_ctrl.sv @@
module smo_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_busy,
  output logic            in_ready,
  output smo_pkg::smo_cmd_t cmd
);
  import smo_pkg::*;
  `include "sliding_mode_rotor_angle_observer_assert.svh"

  smo_state_t state, state_next;
  logic       axis, axis_next;
  logic [3:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    step_next  = step;
    unique case (state)
      ST_IDLE:  if (in_fire) begin
        state_next = ST_EST_A;
        axis_next  = 1'b0;
      end
      ST_EST_A: state_next = ST_EST_B;
      ST_EST_B: state_next = ST_ERR;
      ST_ERR:   state_next = ST_CORR;
      ST_CORR:  state_next = ST_EMF_D;
      ST_EMF_D: state_next = ST_EMF;
      ST_EMF: begin
        if (axis == 1'b0) begin
          axis_next  = 1'b1;
          state_next = ST_EST_A;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM:  state_next = ST_FOLD;
      ST_FOLD: begin
        state_next = ST_ROT;
        step_next  = '0;
      end
      ST_ROT: begin
        if (step == 4'(CordicSteps - 1)) state_next = ST_OUT;
        step_next = step + 4'd1;
      end
      ST_OUT:   if (!out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.axis     = axis;
    cmd.step     = step;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE:  begin
        in_ready = 1'b1;
        if (in_fire) cmd.op = OP_LOAD;
      end
      ST_EST_A: cmd.op = OP_EST_A;
      ST_EST_B: cmd.op = OP_EST_B;
      ST_ERR:   cmd.op = OP_ERR;
      ST_CORR:  cmd.op = OP_CORR;
      ST_EMF_D: cmd.op = OP_EMF_D;
      ST_EMF:   cmd.op = OP_EMF;
      ST_NORM:  cmd.op = OP_NORM;
      ST_FOLD:  cmd.op = OP_FOLD;
      ST_ROT:   cmd.op = OP_ROT;
      ST_OUT:   cmd.out_load = !out_busy;
      default:  cmd.op = OP_NONE;
    endcase
  end

  `SMO_ASSERT_NEXT(a_rot_len, clk, rst, state == ST_FOLD, state == ST_ROT && step == 4'd0)
  `SMO_ASSERT_IMPL(a_step_rng, clk, rst, state == ST_ROT, step < 4'(CordicSteps))
  `SMO_ASSERT_NEXT(a_start, clk, rst, in_fire, state == ST_EST_A && axis == 1'b0)
endmodule

@@ sv/smo_dp.sv @@
module smo_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  smo_pkg::smo_cmd_t    cmd,
  input  logic [63:0]          in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [14:0]          cfg_val,
  output logic [15:0]          res_angle,
  output logic [15:0]          res_emf_a,
  output logic [15:0]          res_emf_b
);
  import smo_pkg::*;

  logic [14:0] gain_a, gain_b, gain_h, gain_k;
  logic [15:0] v_a, v_b, i_a, i_b;
  logic [31:0] est [2];
  logic [31:0] corr [2];
  logic [31:0] emf [2];
  logic [31:0] prod;   // registered product term
  logic [31:0] errc;
  logic signed [15:0] px, py;
  logic signed [31:0] xi, yi;
  logic [15:0] ang;

  // one shared 32x32 multiplier, wrapping, then >>>15
  logic [31:0] mul_a, mul_b, mul_p, q15;
  assign mul_p = mul_a * mul_b;
  assign q15   = 32'($signed(mul_p) >>> 15);

  logic [31:0] v_sel, i_sel, err_raw;
  logic signed [31:0] err_s;
  assign v_sel = cmd.axis ? 32'($signed(v_b)) : 32'($signed(v_a));
  assign i_sel = cmd.axis ? 32'($signed(i_b)) : 32'($signed(i_a));
  assign err_raw = est[cmd.axis] - i_sel;
  assign err_s = $signed(err_raw);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_EST_A: begin
        mul_a = v_sel - corr[cmd.axis];
        mul_b = 32'(gain_a);
      end
      OP_EST_B: begin
        mul_a = est[cmd.axis];
        mul_b = 32'(gain_b);
      end
      OP_CORR: begin
        mul_a = 32'(gain_h);
        mul_b = errc;
      end
      OP_EMF_D: begin
        mul_a = 32'(gain_k);
        mul_b = corr[cmd.axis] - emf[cmd.axis];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // normalization on the leading one of |x|+|y|
  logic [15:0] mag0, mag;
  logic [4:0]  lz;
  logic signed [15:0] npx, npy;
  assign mag0 = px[15] ? 16'(-px) : px;
  assign mag  = (py > 0) ? mag0 + py : mag0 - py;
  always_comb begin
    lz = 5'd16;
    for (int k = 0; k < 16; k++) if (mag[k]) lz = 5'(15 - k);
  end
  always_comb begin
    if (lz == 5'd16) begin
      npx = px;
      npy = py;
    end else if (lz == 5'd0) begin
      npx = px >>> 1;
      npy = py >>> 1;
    end else begin
      npx = px << (lz - 5'd1);
      npy = py << (lz - 5'd1);
    end
  end

  logic signed [31:0] hpx, hpy, sxi, syi;
  assign hpx = 32'(px >>> 1);
  assign hpy = 32'(py >>> 1);
  assign sxi = xi >>> cmd.step;
  assign syi = yi >>> cmd.step;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_a <= '0;
      gain_b <= '0;
      gain_h <= '0;
      gain_k <= '0;
      est[0] <= '0;
      est[1] <= '0;
      corr[0] <= '0;
      corr[1] <= '0;
      emf[0] <= '0;
      emf[1] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          RegInputGain:  gain_a <= cfg_val;
          RegDecayGain:  gain_b <= cfg_val;
          RegSwitchGain: gain_h <= cfg_val;
          RegFilterCoef: gain_k <= cfg_val;
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_EST_B: est[cmd.axis] <= prod + q15;
        OP_CORR:  corr[cmd.axis] <= q15;
        OP_EMF:   emf[cmd.axis] <= emf[cmd.axis] + prod;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        v_a <= in_data[15:0];
        v_b <= in_data[31:16];
        i_a <= in_data[47:32];
        i_b <= in_data[63:48];
      end
      OP_EST_A, OP_EMF_D: prod <= q15;
      OP_ERR: begin
        if (err_s > ErrLimit) errc <= ErrLimit;
        else if (err_s < -ErrLimit) errc <= -ErrLimit;
        else errc <= err_raw;
      end
      OP_EMF: if (cmd.axis) begin
        px <= 16'(emf[1] + prod);
        py <= 16'(emf[0]);
      end
      OP_NORM: begin
        px <= npx;
        py <= npy;
      end
      OP_FOLD: begin
        if (px < 0) begin
          if (py < 0) begin
            ang <= 16'd16384;
            xi  <= -hpy;
            yi  <= hpx;
          end else begin
            ang <= 16'(-16384);
            xi  <= hpy;
            yi  <= -hpx;
          end
        end else begin
          ang <= '0;
          xi  <= hpx;
          yi  <= hpy;
        end
      end
      OP_ROT: begin
        if (yi < 0) begin
          ang <= ang + cordic_atan(cmd.step);
          xi  <= xi - syi;
          yi  <= sxi + yi;
        end else begin
          ang <= ang - cordic_atan(cmd.step);
          xi  <= xi + syi;
          yi  <= yi - sxi;
        end
      end
      default: ;
    endcase
  end

  assign res_angle = ang;
  assign res_emf_a = emf[0][15:0];
  assign res_emf_b = emf[1][15:0];
endmodule

@@ tb/tb_sliding_mode_rotor_angle_observer.sv @@
`timescale 1ns / 100ps

module tb_sliding_mode_rotor_angle_observer;
  import smo_pkg::*;

  // Angle of a zero EMF pair: no normalize shift, every step subtracts.
  localparam logic [15:0] ZeroPairAngle = 16'hB90E;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems = 154;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // voltage_alpha[15:0], voltage_beta[31:16], current_alpha[47:32], current_beta[63:48]
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // rotor_angle[15:0], emf_alpha[31:16], emf_beta[47:32]
  logic [47:0] m_axis_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  sliding_mode_rotor_angle_observer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  typedef struct packed {
    logic [15:0] emf_beta;
    logic [15:0] emf_alpha;
    logic [15:0] angle;
  } angle_result_t;

  typedef struct {
    logic [63:0]   data;
    bit            typed;   // expectation given in the row
    angle_result_t want;
  } stim_row_t;

  // observer copy: gains and per-axis state
  logic [31:0] gain_in, gain_decay, gain_switch, gain_filter;
  logic [31:0] est_a, est_b, corr_a, corr_b, emf_a, emf_b;

  angle_result_t angle_q[$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   src_idle_pct, snk_idle_pct;
  bit            row_typed;
  angle_result_t row_want;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  // Q15 product: 32-bit wrapping multiply, arithmetic shift by 15
  function automatic logic [31:0] q15_mul(input logic [31:0] a, input logic [31:0] b);
    logic signed [31:0] p;
    p = a * b;
    return p >>> 15;
  endfunction

  function automatic void axis_step(input logic [15:0] v16, input logic [15:0] i16,
                                    inout logic [31:0] est, inout logic [31:0] corr,
                                    inout logic [31:0] emf);
    logic signed [31:0] err;
    logic [31:0] v, im;
    v   = {{16{v16[15]}}, v16};
    im  = {{16{i16[15]}}, i16};
    est = q15_mul(v - corr, gain_in) + q15_mul(est, gain_decay);
    err = est - im;
    if (err > ErrLimit) err = ErrLimit;
    else if (err < -ErrLimit) err = -ErrLimit;
    corr = q15_mul(gain_switch, err);
    emf  = emf + q15_mul(gain_filter, corr - emf);
  endfunction

  function automatic logic [15:0] rotor_angle_of(input int px_in, input int py_in);
    int px, py, xi, yi, xo;
    logic [15:0] mag, ang, steps [10];
    logic [31:0] sh;
    bit found;
    steps = '{16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651,
              16'd326, 16'd163, 16'd81, 16'd41, 16'd20};
    px = px_in;
    py = py_in;
    mag = 16'((px < 0) ? -px : px);
    mag = 16'((py > 0) ? mag + py : mag - py);
    found = 0;
    // normalize on the leading one of |x|+|y|; shifts wrap at 16 bits
    for (int i = 0; i < 16; i++) begin
      if (!found && mag[15-i]) begin
        found = 1;
        if (i == 0) begin
          px = px >>> 1;
          py = py >>> 1;
        end else begin
          sh = px << (i - 1);
          px = $signed(sh[15:0]);
          sh = py << (i - 1);
          py = $signed(sh[15:0]);
        end
      end
    end
    // quadrant fold into the right half plane
    if (px < 0) begin
      if (py < 0) begin
        ang = 16'd16384;
        xi = -(py >>> 1);
        yi = px >>> 1;
      end else begin
        ang = -16'sd16384;
        xi = py >>> 1;
        yi = -(px >>> 1);
      end
    end else begin
      ang = 16'd0;
      xi = px >>> 1;
      yi = py >>> 1;
    end
    for (int i = 0; i < 10; i++) begin
      xo = xi;
      if (yi < 0) begin
        ang = ang + steps[i];
        xi = xi - (yi >>> i);
        yi = (xo >>> i) + yi;
      end else begin
        ang = ang - steps[i];
        xi = xi + (yi >>> i);
        yi = yi - (xo >>> i);
      end
    end
    return ang;
  endfunction

  function automatic angle_result_t observe(input logic [63:0] d);
    angle_result_t r;
    axis_step(d[15:0], d[47:32], est_a, corr_a, emf_a);
    axis_step(d[31:16], d[63:48], est_b, corr_b, emf_b);
    r.angle     = rotor_angle_of($signed(emf_b[15:0]), $signed(emf_a[15:0]));
    r.emf_alpha = emf_a[15:0];
    r.emf_beta  = emf_b[15:0];
    return r;
  endfunction

  // Input transfer: advance the observer copy and queue the expectation.
  always @(posedge clk) begin
    angle_result_t r;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      r = observe(s_axis_tdata);
      angle_q.push_back(row_typed ? row_want : r);
    end
  end

  // Output transfer: compare against the oldest expectation.
  always @(posedge clk) begin
    angle_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (angle_q.size() == 0) begin
        report_mismatch("unexpected rotor_angle", got.angle, 16'hxxxx);
      end else begin
        want = angle_q.pop_front();
        if (got.angle !== want.angle) report_mismatch("rotor_angle", got.angle, want.angle);
        if (got.emf_alpha !== want.emf_alpha)
          report_mismatch("emf_alpha", got.emf_alpha, want.emf_alpha);
        if (got.emf_beta !== want.emf_beta)
          report_mismatch("emf_beta", got.emf_beta, want.emf_beta);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_sliding_mode_rotor_angle_observer failed");
      $finish;
    end
  end

  // Receiver backpressure, drawn per cycle.
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      RegInputGain:  gain_in     = 32'(val);
      RegDecayGain:  gain_decay  = 32'(val);
      RegSwitchGain: gain_switch = 32'(val);
      RegFilterCoef: gain_filter = 32'(val);
      default: ;
    endcase
  endtask

  task automatic write_gains(input logic [14:0] a, input logic [14:0] b,
                             input logic [14:0] h, input logic [14:0] k);
    write_reg(RegInputGain, a);
    write_reg(RegDecayGain, b);
    write_reg(RegSwitchGain, h);
    write_reg(RegFilterCoef, k);
  endtask

  // Block idle: every result in, then the pipeline latency on top.
  task automatic wait_drained();
    while (angle_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // One transfer on the input side, with random idle gaps ahead of it.
  task automatic send_item(input logic [63:0] d, input bit typed, input angle_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    row_typed     = typed;
    row_want      = want;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    row_typed     = 1'b0;
  endtask

  function automatic logic [63:0] random_item();
    logic [63:0] d;
    d = {$urandom, $urandom};
    // mostly realistic drive levels, sometimes full-scale noise
    if ($urandom_range(3) != 0)
      for (int f = 0; f < 4; f++)
        d[16*f +: 16] = $signed(d[16*f +: 16]) >>> $urandom_range(6, 1);
    return d;
  endfunction

  function automatic logic [14:0] random_gain();
    case ($urandom_range(5))
      0: return 15'd0;
      1: return 15'h7FFF;
      default: return 15'($urandom);
    endcase
  endfunction

  stim_row_t   dir_rows[$];
  stim_row_t   row;
  angle_result_t zero_res;

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    row_typed = 1'b0;
    row_want = '0;
    {gain_in, gain_decay, gain_switch, gain_filter} = '0;
    {est_a, est_b, corr_a, corr_b, emf_a, emf_b} = '0;

    // gains zero after reset: EMF stays zero, angle is that of the zero pair
    zero_res = '{emf_beta: 16'h0, emf_alpha: 16'h0, angle: ZeroPairAngle};
    dir_rows.push_back('{64'h0, 1'b1, zero_res});
    dir_rows.push_back('{64'h8000_8000_8000_8000, 1'b1, zero_res});
    dir_rows.push_back('{64'h7FFF_7FFF_7FFF_7FFF, 1'b1, zero_res});
    dir_rows.push_back('{64'h8000_7FFF_7FFF_8000, 1'b1, zero_res});
    dir_rows.push_back('{64'hFFFF_0001_FFFF_0001, 1'b1, zero_res});

    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[n]) send_item(dir_rows[n].data, dir_rows[n].typed, dir_rows[n].want);
    wait_drained();

    // all gains at maximum: errors clamp, EMF swings hard in every quadrant
    write_gains(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    dir_rows.delete();
    dir_rows.push_back('{64'h7FFF_7FFF_8000_8000, 1'b0, zero_res});
    dir_rows.push_back('{64'h7FFF_7FFF_8000_8000, 1'b0, zero_res});
    dir_rows.push_back('{64'h8000_8000_7FFF_7FFF, 1'b0, zero_res});
    dir_rows.push_back('{64'h8000_7FFF_7FFF_8000, 1'b0, zero_res});
    dir_rows.push_back('{64'h7FFF_8000_8000_7FFF, 1'b0, zero_res});
    dir_rows.push_back('{64'h0000_0000_0000_0000, 1'b0, zero_res});
    dir_rows.push_back('{64'h0001_FFFF_0001_FFFF, 1'b0, zero_res});
    foreach (dir_rows[n]) send_item(dir_rows[n].data, 1'b0, zero_res);
    wait_drained();

    // moderate gains: small EMF values exercise deep normalize shifts
    write_gains(15'd1200, 15'd31000, 15'd300, 15'd4000);
    for (int n = 0; n < 8; n++) send_item({$urandom, $urandom} >> ($urandom_range(3) * 16),
                                          1'b0, zero_res);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1: begin src_idle_pct = 81; snk_idle_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_idle_pct = 81; end
        default: begin src_idle_pct = 12; snk_idle_pct = 12; end
      endcase
      if (p == 0) write_gains(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
      else if (p == 4) write_gains(15'd0, 15'd0, 15'd0, 15'd0);
      else write_gains(random_gain(), random_gain(), random_gain(), random_gain());
      for (int n = 0; n < PhaseItems; n++) begin
        // hold off once until the output side has caught up
        if (p == 3 && n == PhaseItems / 2)
          while (angle_q.size() != 0) @(negedge clk);
        send_item(random_item(), 1'b0, zero_res);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb_sliding_mode_rotor_angle_observer passed");
    end else begin
      $display("tb_sliding_mode_rotor_angle_observer failed");
    end
    $finish;
  end

endmodule
